// ----- rtl/vvsr_pkg.sv -----
// Shared types, codes and address helpers for the video scroll register block.
// This file depends on nothing. Every other file in rtl imports it.
package vvsr_pkg;

  localparam int NT_BYTES  = 2048;
  localparam int NT_AW     = $clog2(NT_BYTES);
  localparam int SPR_BYTES = 256;
  localparam int SPR_AW    = $clog2(SPR_BYTES);
  localparam int PAL_BYTES = 32;
  localparam int CLR_CW    = NT_AW + 1;

  localparam logic [2:0] REQ_RD     = 3'd0;
  localparam logic [2:0] REQ_WR     = 3'd1;
  localparam logic [2:0] REQ_LINE   = 3'd2;
  localparam logic [2:0] REQ_VB_SET = 3'd3;
  localparam logic [2:0] REQ_VB_CLR = 3'd4;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMA   = 3'd3;
  localparam logic [2:0] REG_OAMD   = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [1:0] CA_NONE = 2'd0;
  localparam logic [1:0] CA_RD   = 2'd1;
  localparam logic [1:0] CA_WR   = 2'd2;

  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;
  localparam logic [1:0] MIR_LOW  = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] scanline_number;
    logic [7:0] cart_rdata;
    logic       sprite_hit_in;
    logic       sprite_overflow_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi;
    logic [1:0]  cart_access;
    logic [13:0] cart_addr;
    logic [7:0]  cart_wdata;
  } out_t;

  // Nametable index for a 14-bit video address under the given mirroring.
  function automatic logic [NT_AW-1:0] nt_index(input logic [13:0] a, input logic [1:0] mode);
    logic bank;
    logic [10:0] idx;
    case (mode)
      MIR_VERT: bank = a[10];
      MIR_HORZ: bank = a[11];
      MIR_LOW:  bank = 1'b0;
      default:  bank = 1'b1;
    endcase
    idx = {bank, a[9:0]};
    return NT_AW'(idx);
  endfunction

  // Palette index; the sprite backdrop entries alias the background ones.
  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[4] && (i[1:0] == 2'b00)) begin
      i[4] = 1'b0;
    end
    return i;
  endfunction

  // Vertical step of the current address: fine y, then coarse y with the
  // nametable flip at row 29 and a plain wrap from row 31.
  function automatic logic [15:0] inc_y(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0] cy;
    r = v;
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      cy = v[9:5];
      if (cy == 5'd29) begin
        cy = 5'd0;
        r[11] = ~v[11];
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r[9:5] = cy;
    end
    return r;
  endfunction

endpackage

// ----- rtl/vvsr_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
// A read of the address being written returns the new data. Uses vvsr_pkg.
module vvsr_ram
  import vvsr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/video_vram_scroll_registers.sv -----
// Top level of the picture processor register file with scroll registers.
// Depends on vvsr_pkg and vvsr_ram.
//
// Use of the block:
// The input channel (in_valid, in_ready, in_data) carries one request per
// transfer: a CPU read or write of one of the eight registers, a scanline
// event or a vblank start or end. Every request gives exactly one result on
// the output channel (out_valid, out_ready, out_data).
// A request taken is held in an input register; it is then applied to the
// state and loads the result register once that register is free. One
// request a cycle is sustained while the receiver does not stall.
// The nametable and sprite memories are read ahead of use, addressed by
// the next value of the video address and sprite address, so the registered
// read data is ready when the request is applied.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more request; further requests wait.
// After reset the block clears the nametable and the sprite memory, one
// entry a cycle, with in_ready low throughout. The mirror mode register
// may be written at any time, but only while the block is idle if
// requests are to see a consistent mapping.
module video_vram_scroll_registers
  import vvsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  // Pipeline and clearing control.
  logic              in_vld_r, out_vld_r, clr_r;
  in_t               in_r;
  out_t              out_r, out_nxt;
  logic [CLR_CW-1:0] clr_cnt_r;
  logic              advance, in_fire;

  // Architectural state.
  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt, mask_r, mask_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [14:0] t_r, t_nxt;
  logic [15:0] v_r, v_nxt;
  logic [2:0]  fx_r, fx_nxt;
  logic        tog_r, tog_nxt;
  logic [7:0]  sma_r, sma_nxt;
  logic [7:0]  buf_r, buf_nxt;
  logic [7:0]  pal_r [PAL_BYTES];

  // Memory ports.
  logic             nt_we, spr_we, pal_we;
  logic [NT_AW-1:0] nt_waddr;
  logic [7:0]       nt_wdata, nt_rdata, spr_rdata;
  logic [7:0]       pal_val;
  logic [13:0]      a;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !clr_r && (!in_vld_r || advance);
  assign in_fire  = in_valid && in_ready;
  assign a        = v_r[13:0];
  assign pal_val  = pal_r[pal_index(a)] & (mask_r[0] ? 8'h30 : 8'h3F);

  // Apply the held request to the state and form its result.
  always_comb begin
    ctrl_nxt = ctrl_r;
    mask_nxt = mask_r;
    stat_nxt = stat_r;
    t_nxt    = t_r;
    v_nxt    = v_r;
    fx_nxt   = fx_r;
    tog_nxt  = tog_r;
    sma_nxt  = sma_r;
    buf_nxt  = buf_r;
    out_nxt  = '0;
    nt_we    = 1'b0;
    spr_we   = 1'b0;
    pal_we   = 1'b0;
    if (advance) begin
      case (in_r.req_type)
        REQ_RD: begin
          case (in_r.reg_index)
            REG_STATUS: begin
              out_nxt.read_data = {stat_r, 5'b0};
              stat_nxt          = {1'b0, stat_r[1:0]};
              tog_nxt           = 1'b0;
            end
            REG_OAMD: out_nxt.read_data = spr_rdata;
            REG_DATA: begin
              out_nxt.read_data = buf_r;
              if (a < 14'h2000) begin
                out_nxt.cart_access = CA_RD;
                out_nxt.cart_addr   = a;
                buf_nxt             = in_r.cart_rdata;
              end else if (a < 14'h3F00) begin
                buf_nxt = nt_rdata;
              end else begin
                buf_nxt           = pal_val;
                out_nxt.read_data = pal_val;
              end
              v_nxt = v_r + (ctrl_r[2] ? 16'd32 : 16'd1);
            end
            default: ;
          endcase
        end
        REQ_WR: begin
          case (in_r.reg_index)
            REG_CTRL: begin
              ctrl_nxt       = in_r.write_data;
              t_nxt[11:10]   = in_r.write_data[1:0];
            end
            REG_MASK: mask_nxt = in_r.write_data;
            REG_OAMA: sma_nxt  = in_r.write_data;
            REG_OAMD: begin
              spr_we  = 1'b1;
              sma_nxt = sma_r + 8'd1;
            end
            REG_SCROLL: begin
              if (!tog_r) begin
                fx_nxt     = in_r.write_data[2:0];
                t_nxt[4:0] = in_r.write_data[7:3];
              end else begin
                t_nxt[14:12] = in_r.write_data[2:0];
                t_nxt[9:5]   = in_r.write_data[7:3];
              end
              tog_nxt = ~tog_r;
            end
            REG_ADDR: begin
              if (!tog_r) begin
                t_nxt[14:8] = {1'b0, in_r.write_data[5:0]};
              end else begin
                t_nxt[7:0] = in_r.write_data;
                v_nxt      = {1'b0, t_r[14:8], in_r.write_data};
              end
              tog_nxt = ~tog_r;
            end
            REG_DATA: begin
              if (a < 14'h2000) begin
                out_nxt.cart_access = CA_WR;
                out_nxt.cart_addr   = a;
                out_nxt.cart_wdata  = in_r.write_data;
              end else if (a < 14'h3F00) begin
                nt_we = 1'b1;
              end else begin
                pal_we = 1'b1;
              end
              v_nxt = v_r + (ctrl_r[2] ? 16'd32 : 16'd1);
            end
            default: ;
          endcase
        end
        REQ_LINE: begin
          if (mask_r[4] || mask_r[3]) begin
            if (in_r.scanline_number == 8'd0) begin
              v_nxt = inc_y({1'b0, t_r});
            end else begin
              v_nxt = inc_y({v_r[15:11], t_r[10], v_r[9:5], t_r[4:0]});
            end
          end
          stat_nxt = stat_r | {1'b0, in_r.sprite_hit_in, in_r.sprite_overflow_in};
        end
        REQ_VB_SET: begin
          stat_nxt    = stat_r | 3'b100;
          out_nxt.nmi = ctrl_r[7];
        end
        REQ_VB_CLR: stat_nxt = 3'b000;
        default: ;
      endcase
    end
  end

  // The clearing pass owns the write ports after reset.
  assign nt_waddr = clr_r ? clr_cnt_r[NT_AW-1:0] : nt_index(a, mirror_r);
  assign nt_wdata = clr_r ? 8'h00 : in_r.write_data;

  vvsr_ram #(.DEPTH(NT_BYTES)) u_nt_ram (
    .clk   (clk),
    .we    (clr_r || nt_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .raddr (nt_index(v_nxt[13:0], mirror_r)),
    .rdata (nt_rdata)
  );

  vvsr_ram #(.DEPTH(SPR_BYTES)) u_spr_ram (
    .clk   (clk),
    .we    (clr_r || spr_we),
    .waddr (clr_r ? clr_cnt_r[SPR_AW-1:0] : sma_r),
    .wdata (clr_r ? 8'h00 : in_r.write_data),
    .raddr (sma_nxt),
    .rdata (spr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      mirror_r  <= MIR_VERT;
      ctrl_r    <= '0;
      mask_r    <= '0;
      stat_r    <= '0;
      t_r       <= '0;
      v_r       <= '0;
      fx_r      <= '0;
      tog_r     <= 1'b0;
      sma_r     <= '0;
      buf_r     <= '0;
      for (int i = 0; i < PAL_BYTES; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + CLR_CW'(1);
        if (clr_cnt_r == CLR_CW'(NT_BYTES - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        mirror_r <= cfg_wr_data;
      end
      in_vld_r  <= in_fire || (in_vld_r && !advance);
      out_vld_r <= advance || (out_vld_r && !out_ready);
      ctrl_r    <= ctrl_nxt;
      mask_r    <= mask_nxt;
      stat_r    <= stat_nxt;
      t_r       <= t_nxt;
      v_r       <= v_nxt;
      fx_r      <= fx_nxt;
      tog_r     <= tog_nxt;
      sma_r     <= sma_nxt;
      buf_r     <= buf_nxt;
      if (pal_we) begin
        pal_r[pal_index(a)] <= in_r.write_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // The fine x register is kept for the renderer but nothing here reads it
  // beyond the check below.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready) else $error("request taken during memory clearing");

  a_cart_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cart_access != 2'd3) else $error("bad cartridge code");

  a_nmi_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.nmi) |-> (out_data.read_data == 8'h00 &&
      out_data.cart_access == CA_NONE)) else $error("nmi with other result");

  a_fine_x_scroll_only: assert property (@(posedge clk) disable iff (!rst_n)
    (fx_r != $past(fx_r)) |-> $past(advance && in_r.req_type == REQ_WR &&
      in_r.reg_index == REG_SCROLL && !tog_r)) else $error("fine x changed unexpectedly");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for video_vram_scroll_registers.
// Depends on vvsr_pkg (request codes, register numbers, payload structs) and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import vvsr_pkg::*;

  localparam logic [1:0] MIR_HIGH    = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #1 clk = ~clk;

  video_vram_scroll_registers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Requests waiting to be offered, and the results we expect back, in order.
  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   error_count = 0;
  int   cycle_count = 0;

  // Idling knobs, set by the sequencing block for each phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  // Our own copy of the block's state, used to work out each result.
  logic [1:0]  mirror;
  logic [7:0]  ctrl_q, mask_q, oam_addr_q, read_buf_q;
  logic [2:0]  status_q, fine_x_q;
  logic [14:0] tmp_addr_q;
  logic [15:0] cur_addr_q;
  logic        toggle_q;
  logic [7:0]  nt_copy[NT_BYTES];
  logic [7:0]  pal_copy[PAL_BYTES];
  logic [7:0]  oam_copy[SPR_BYTES];

  task automatic clear_model();
    mirror = MIR_VERT;
    ctrl_q = '0; mask_q = '0; oam_addr_q = '0; read_buf_q = '0;
    status_q = '0; fine_x_q = '0; tmp_addr_q = '0; cur_addr_q = '0; toggle_q = 1'b0;
    foreach (nt_copy[i]) nt_copy[i] = '0;
    foreach (pal_copy[i]) pal_copy[i] = '0;
    foreach (oam_copy[i]) oam_copy[i] = '0;
  endtask

  // Nametable slot: the mirroring picks which of the two 1 KB banks a page uses.
  function automatic int unsigned nt_slot(logic [13:0] a);
    logic bank;
    case (mirror)
      MIR_VERT: bank = a[10];
      MIR_HORZ: bank = a[11];
      MIR_LOW:  bank = 1'b0;
      default:  bank = 1'b1;
    endcase
    return {bank, a[9:0]} % NT_BYTES;
  endfunction

  // Palette slot: sprite entries 0x10, 0x14, 0x18 and 0x1C fold onto the backdrop ones.
  function automatic int unsigned pal_slot(logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if ((i & 5'h13) == 5'h10) i = i ^ 5'h10;
    return i;
  endfunction

  // Fine y steps first; on overflow coarse y advances, flipping the vertical
  // nametable at row 29 and wrapping silently from row 31.
  function automatic logic [15:0] step_down(logic [15:0] v);
    logic [4:0] row;
    if (v[14:12] != 3'd7) return v + 16'h1000;
    v[14:12] = 3'd0;
    row = v[9:5];
    if (row == 5'd29) begin
      row = 5'd0;
      v[11] = ~v[11];
    end else if (row == 5'd31) begin
      row = 5'd0;
    end else begin
      row = row + 5'd1;
    end
    v[9:5] = row;
    return v;
  endfunction

  // Applies one accepted request to the local state and queues its result.
  task automatic apply_request(in_t x);
    out_t r;
    logic [13:0] a;
    logic [7:0] nb;
    r = '0;
    a = cur_addr_q[13:0];
    case (x.req_type)
      REQ_RD: begin
        if (x.reg_index == REG_STATUS) begin
          r.read_data = {status_q, 5'b0};
          status_q[2] = 1'b0;
          toggle_q = 1'b0;
        end else if (x.reg_index == REG_OAMD) begin
          r.read_data = oam_copy[oam_addr_q];
        end else if (x.reg_index == REG_DATA) begin
          r.read_data = read_buf_q;
          if (a < 14'h2000) begin
            r.cart_access = CA_RD;
            r.cart_addr = a;
            nb = x.cart_rdata;
          end else if (a < 14'h3F00) begin
            nb = nt_copy[nt_slot(a)];
          end else begin
            // Palette reads bypass the buffer, with grayscale masking.
            nb = pal_copy[pal_slot(a)] & (mask_q[0] ? 8'h30 : 8'h3F);
            r.read_data = nb;
          end
          read_buf_q = nb;
          cur_addr_q = cur_addr_q + (ctrl_q[2] ? 16'd32 : 16'd1);
        end
      end
      REQ_WR: begin
        case (x.reg_index)
          REG_CTRL: begin
            ctrl_q = x.write_data;
            tmp_addr_q[11:10] = x.write_data[1:0];
          end
          REG_MASK: mask_q = x.write_data;
          REG_OAMA: oam_addr_q = x.write_data;
          REG_OAMD: begin
            oam_copy[oam_addr_q] = x.write_data;
            oam_addr_q = oam_addr_q + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_q) begin
              fine_x_q = x.write_data[2:0];
              tmp_addr_q[4:0] = x.write_data[7:3];
            end else begin
              tmp_addr_q[14:12] = x.write_data[2:0];
              tmp_addr_q[9:5] = x.write_data[7:3];
            end
            toggle_q = ~toggle_q;
          end
          REG_ADDR: begin
            if (!toggle_q) begin
              tmp_addr_q = {1'b0, x.write_data[5:0], tmp_addr_q[7:0]};
            end else begin
              tmp_addr_q[7:0] = x.write_data;
              cur_addr_q = {1'b0, tmp_addr_q};
            end
            toggle_q = ~toggle_q;
          end
          REG_DATA: begin
            if (a < 14'h2000) begin
              r.cart_access = CA_WR;
              r.cart_addr = a;
              r.cart_wdata = x.write_data;
            end else if (a < 14'h3F00) begin
              nt_copy[nt_slot(a)] = x.write_data;
            end else begin
              pal_copy[pal_slot(a)] = x.write_data;
            end
            cur_addr_q = cur_addr_q + (ctrl_q[2] ? 16'd32 : 16'd1);
          end
          default: ;
        endcase
      end
      REQ_LINE: begin
        // With rendering off the address stays put, but the flags still land.
        if (mask_q[4:3] != 2'b00) begin
          if (x.scanline_number == 8'd0)
            cur_addr_q = {1'b0, tmp_addr_q};
          else
            cur_addr_q = (cur_addr_q & ~16'h041F) | ({1'b0, tmp_addr_q} & 16'h041F);
          cur_addr_q = step_down(cur_addr_q);
        end
        if (x.sprite_hit_in) status_q[1] = 1'b1;
        if (x.sprite_overflow_in) status_q[0] = 1'b1;
      end
      REQ_VB_SET: begin
        status_q[2] = 1'b1;
        r.nmi = ctrl_q[7];
      end
      REQ_VB_CLR: status_q = '0;
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // Driver: offers the next pending request, holding it until the transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_request(in_data);
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus an occasional long hold-off that lets the
  // block back up and drop in_ready.
  int hold_left = 0;
  int holds_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_seen != hold_requests) begin
      holds_seen <= holds_seen + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report(string field, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
             cycle_count, field, got, want);
    error_count++;
  endtask

  // Monitor: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result, read_data", out_data.read_data, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report("read_data", out_data.read_data, want.read_data);
        if (out_data.nmi !== want.nmi) report("nmi", out_data.nmi, want.nmi);
        if (out_data.cart_access !== want.cart_access)
          report("cart_access", out_data.cart_access, want.cart_access);
        if (out_data.cart_addr !== want.cart_addr)
          report("cart_addr", out_data.cart_addr, want.cart_addr);
        if (out_data.cart_wdata !== want.cart_wdata)
          report("cart_wdata", out_data.cart_wdata, want.cart_wdata);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Builds one request; scanline, cartridge read data and sprite flags are random whether used or not.
  function automatic in_t req(logic [2:0] kind, logic [2:0] idx, logic [7:0] wd);
    in_t x;
    x.req_type = kind;
    x.reg_index = idx;
    x.write_data = wd;
    x.scanline_number = 8'($urandom_range(239));
    x.cart_rdata = 8'($urandom);
    x.sprite_hit_in = 1'($urandom);
    x.sprite_overflow_in = 1'($urandom);
    return x;
  endfunction

  // A well-formed access pattern with random content, or now and then noise.
  task automatic add_burst();
    in_t x;
    int n;
    logic [7:0] hi;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // Point v somewhere (pattern, nametable or palette range), then data.
        case ($urandom_range(3))
          0: hi = 8'($urandom_range(8'h1F));
          1: hi = 8'($urandom_range(8'h20, 8'h3E));
          2: hi = 8'h3F;
          default: hi = 8'($urandom);
        endcase
        pending_reqs.push_back(req(REQ_WR, REG_ADDR, hi));
        pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'($urandom)));
        n = $urandom_range(1, 6);
        repeat (n)
          pending_reqs.push_back(req($urandom_range(1) ? REQ_RD : REQ_WR, REG_DATA,
                                     8'($urandom)));
      end
      4: begin
        pending_reqs.push_back(req(REQ_WR, REG_CTRL, 8'($urandom)));
        pending_reqs.push_back(req(REQ_WR, REG_MASK, 8'($urandom)));
        pending_reqs.push_back(req(REQ_WR, REG_SCROLL, 8'($urandom)));
        pending_reqs.push_back(req(REQ_WR, REG_SCROLL, 8'($urandom)));
      end
      5: begin
        pending_reqs.push_back(req(REQ_WR, REG_OAMA, 8'($urandom)));
        n = $urandom_range(1, 4);
        repeat (n) pending_reqs.push_back(req(REQ_WR, REG_OAMD, 8'($urandom)));
        pending_reqs.push_back(req(REQ_RD, REG_OAMD, 8'($urandom)));
      end
      6, 7: begin
        // A short frame: vblank start, status poll and vblank end, then a run of scanlines and a last poll.
        pending_reqs.push_back(req(REQ_VB_SET, 3'($urandom), 8'($urandom)));
        pending_reqs.push_back(req(REQ_RD, REG_STATUS, 8'($urandom)));
        pending_reqs.push_back(req(REQ_VB_CLR, 3'($urandom), 8'($urandom)));
        if ($urandom_range(1)) pending_reqs.push_back(req(REQ_WR, REG_MASK, 8'h18));
        x = req(REQ_LINE, 3'($urandom), 8'($urandom));
        x.scanline_number = 8'd0;
        pending_reqs.push_back(x);
        n = $urandom_range(1, 10);
        repeat (n) pending_reqs.push_back(req(REQ_LINE, 3'($urandom), 8'($urandom)));
        pending_reqs.push_back(req(REQ_RD, REG_STATUS, 8'($urandom)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n)
          pending_reqs.push_back(req(3'($urandom), 3'($urandom), 8'($urandom)));
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mirror(logic [1:0] mode);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror = mode;
  endtask

  task automatic run_phase(int count, int send_pct, int recv_pct, logic [1:0] mode,
                           bit long_hold);
    set_mirror(mode);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_requests++;
    while (pending_reqs.size() < count) add_burst();
    wait_drained();
  endtask

  initial begin
    in_t x;
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_mirror(MIR_VERT);

    // Directed opening: every register, each request type, the palette aliases
    // and grayscale, the cartridge and palette address ranges, rendering on, an
    // unused request type and the sprite address wrapping.
    pending_reqs.push_back(req(REQ_WR, REG_CTRL, 8'h84));
    pending_reqs.push_back(req(REQ_WR, REG_MASK, 8'h19));
    pending_reqs.push_back(req(REQ_WR, REG_SCROLL, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_SCROLL, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h3F));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h10));
    pending_reqs.push_back(req(REQ_WR, REG_DATA, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h3F));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h00));
    pending_reqs.push_back(req(REQ_RD, REG_DATA, 8'h00));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h00));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'h00));
    pending_reqs.push_back(req(REQ_WR, REG_DATA, 8'hA5));
    pending_reqs.push_back(req(REQ_RD, REG_DATA, 8'h00));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_ADDR, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_DATA, 8'h5A));
    pending_reqs.push_back(req(REQ_VB_SET, REG_CTRL, 8'h00));
    pending_reqs.push_back(req(REQ_RD, REG_STATUS, 8'h00));
    x = req(REQ_LINE, REG_CTRL, 8'h00);
    x.scanline_number = 8'd0;
    x.sprite_hit_in = 1'b1;
    x.sprite_overflow_in = 1'b1;
    pending_reqs.push_back(x);
    x.scanline_number = 8'd239;
    pending_reqs.push_back(x);
    pending_reqs.push_back(req(REQ_WR, REG_STATUS, 8'hFF));
    pending_reqs.push_back(req(3'd7, REG_DATA, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_OAMA, 8'hFF));
    pending_reqs.push_back(req(REQ_WR, REG_OAMD, 8'hAA));
    pending_reqs.push_back(req(REQ_RD, REG_OAMD, 8'h00));
    pending_reqs.push_back(req(REQ_RD, REG_CTRL, 8'h00));
    pending_reqs.push_back(req(REQ_VB_CLR, REG_CTRL, 8'h00));
    wait_drained();

    run_phase(200, 0, 0, MIR_HORZ, 1'b0);
    run_phase(200, 75, 0, MIR_LOW, 1'b0);
    run_phase(200, 0, 75, MIR_HIGH, 1'b0);
    run_phase(200, 23, 23, MIR_VERT, 1'b0);
    run_phase(200, 0, 0, MIR_HIGH, 1'b1);
    run_phase(200, 23, 23, MIR_HORZ, 1'b0);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vvsr_pkg.sv
rtl/vvsr_ram.sv
rtl/video_vram_scroll_registers.sv
tb/tb_top.sv
